// ----- rtl/utf8cw_pkg.sv -----
package utf8cw_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int CP_W  = 24;
	localparam int WID_W = 2;
	localparam int CFG_W = 9;

	// built-in table
	localparam int RESET_COUNT = 157;
	localparam int ROM_IDX_W   = $clog2(RESET_COUNT);

	localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(RESET_COUNT);
	localparam logic [WID_W-1:0] MISS_WIDTH = WID_W'(1);

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic [CP_W-1:0]  lo;
		logic [CP_W-1:0]  hi;
		logic [WID_W-1:0] width;
	} range_t;

	localparam int RANGE_W = $bits(range_t);

	localparam range_t DEFAULT_TABLE [RESET_COUNT] = '{
		'{24'h00951, 24'h00954, 2'd0}, '{24'h00ccc, 24'h00ccd, 2'd0}, '{24'h0fff9, 24'h0fffb, 2'd0},
		'{24'h20000, 24'h2fffd, 2'd2}, '{24'h00ebb, 24'h00ebc, 2'd0}, '{24'h01932, 24'h01932, 2'd0},
		'{24'h0070f, 24'h0070f, 2'd0}, '{24'h00a70, 24'h00a71, 2'd0}, '{24'h02329, 24'h02329, 2'd2},
		'{24'h00acd, 24'h00acd, 2'd0}, '{24'h00ac7, 24'h00ac8, 2'd0}, '{24'h00a3c, 24'h00a3c, 2'd0},
		'{24'h009cd, 24'h009cd, 2'd0}, '{24'h00591, 24'h005bd, 2'd0}, '{24'h01058, 24'h01059, 2'd0},
		'{24'h0ffe0, 24'h0ffe6, 2'd2}, '{24'h01100, 24'h0115f, 2'd2}, '{24'h0fe20, 24'h0fe23, 2'd0},
		'{24'h0302a, 24'h0302f, 2'd0}, '{24'h01772, 24'h01773, 2'd0}, '{24'h005bf, 24'h005bf, 2'd0},
		'{24'h006ea, 24'h006ed, 2'd0}, '{24'h00bc0, 24'h00bc0, 2'd0}, '{24'h00962, 24'h00963, 2'd0},
		'{24'h01732, 24'h01734, 2'd0}, '{24'h00d41, 24'h00d43, 2'd0}, '{24'h01b42, 24'h01b42, 2'd0},
		'{24'h00a41, 24'h00a42, 2'd0}, '{24'h00eb4, 24'h00eb9, 2'd0}, '{24'h00b01, 24'h00b01, 2'd0},
		'{24'h00e34, 24'h00e3a, 2'd0}, '{24'h03040, 24'h03098, 2'd2}, '{24'h0093c, 24'h0093c, 2'd0},
		'{24'h00c4a, 24'h00c4d, 2'd0}, '{24'h01032, 24'h01032, 2'd0}, '{24'h00f37, 24'h00f37, 2'd0},
		'{24'h00901, 24'h00902, 2'd0}, '{24'h00cbf, 24'h00cbf, 2'd0}, '{24'h0a806, 24'h0a806, 2'd0},
		'{24'h00dd2, 24'h00dd4, 2'd0}, '{24'h00f71, 24'h00f7e, 2'd0}, '{24'h01752, 24'h01753, 2'd0},
		'{24'h1d242, 24'h1d244, 2'd0}, '{24'h005c1, 24'h005c2, 2'd0}, '{24'h0309b, 24'h0a4cf, 2'd2},
		'{24'he0100, 24'he01ef, 2'd0}, '{24'h017dd, 24'h017dd, 2'd0}, '{24'h00600, 24'h00603, 2'd0},
		'{24'h009e2, 24'h009e3, 2'd0}, '{24'h00cc6, 24'h00cc6, 2'd0}, '{24'h0a80b, 24'h0a80b, 2'd0},
		'{24'h01712, 24'h01714, 2'd0}, '{24'h00b3c, 24'h00b3c, 2'd0}, '{24'h01b00, 24'h01b03, 2'd0},
		'{24'h007eb, 24'h007f3, 2'd0}, '{24'he0001, 24'he0001, 2'd0}, '{24'h1d185, 24'h1d18b, 2'd0},
		'{24'h0feff, 24'h0feff, 2'd0}, '{24'h01b36, 24'h01b3a, 2'd0}, '{24'h01920, 24'h01922, 2'd0},
		'{24'h00670, 24'h00670, 2'd0}, '{24'h00f90, 24'h00f97, 2'd0}, '{24'h01927, 24'h01928, 2'd0},
		'{24'h0200b, 24'h0200f, 2'd0}, '{24'h0ff00, 24'h0ff60, 2'd2}, '{24'h0f900, 24'h0faff, 2'd2},
		'{24'h0fb1e, 24'h0fb1e, 2'd0}, '{24'h00cbc, 24'h00cbc, 2'd0}, '{24'h00eb1, 24'h00eb1, 2'd0},
		'{24'h10a38, 24'h10a3a, 2'd0}, '{24'h007a6, 24'h007b0, 2'd0}, '{24'h00f80, 24'h00f84, 2'd0},
		'{24'h005c4, 24'h005c5, 2'd0}, '{24'h0ac00, 24'h0d7a3, 2'd2}, '{24'h017c9, 24'h017d3, 2'd0},
		'{24'h00d4d, 24'h00d4d, 2'd0}, '{24'h1d167, 24'h1d169, 2'd0}, '{24'h01036, 24'h01037, 2'd0},
		'{24'he0020, 24'he007f, 2'd0}, '{24'h00f35, 24'h00f35, 2'd0}, '{24'h017b4, 24'h017b5, 2'd0},
		'{24'h0206a, 24'h0206f, 2'd0}, '{24'h00c46, 24'h00c48, 2'd0}, '{24'h01939, 24'h0193b, 2'd0},
		'{24'h01dc0, 24'h01dca, 2'd0}, '{24'h10a0c, 24'h10a0f, 2'd0}, '{24'h0102d, 24'h01030, 2'd0},
		'{24'h017c6, 24'h017c6, 2'd0}, '{24'h00ec8, 24'h00ecd, 2'd0}, '{24'h00b41, 24'h00b43, 2'd0},
		'{24'h017b7, 24'h017bd, 2'd0}, '{24'h1d173, 24'h1d182, 2'd0}, '{24'h00a47, 24'h00a48, 2'd0},
		'{24'h0232a, 24'h0232a, 2'd2}, '{24'h01b3c, 24'h01b3c, 2'd0}, '{24'h10a01, 24'h10a03, 2'd0},
		'{24'h00ae2, 24'h00ae3, 2'd0}, '{24'h00483, 24'h00486, 2'd0}, '{24'h0135f, 24'h0135f, 2'd0},
		'{24'h01a17, 24'h01a18, 2'd0}, '{24'h006e7, 24'h006e8, 2'd0}, '{24'h03099, 24'h0309a, 2'd0},
		'{24'h00b4d, 24'h00b4d, 2'd0}, '{24'h00ce2, 24'h00ce3, 2'd0}, '{24'h00bcd, 24'h00bcd, 2'd0},
		'{24'h00610, 24'h00615, 2'd0}, '{24'h00f99, 24'h00fbc, 2'd0}, '{24'h009c1, 24'h009c4, 2'd0},
		'{24'h00730, 24'h0074a, 2'd0}, '{24'h00300, 24'h0036f, 2'd0}, '{24'h03030, 24'h0303e, 2'd2},
		'{24'h01b34, 24'h01b34, 2'd0}, '{24'h1d1aa, 24'h1d1ad, 2'd0}, '{24'h00dca, 24'h00dca, 2'd0},
		'{24'h006d6, 24'h006e4, 2'd0}, '{24'h00f86, 24'h00f87, 2'd0}, '{24'h00b3f, 24'h00b3f, 2'd0},
		'{24'h0fe30, 24'h0fe6f, 2'd2}, '{24'h01039, 24'h01039, 2'd0}, '{24'h0094d, 24'h0094d, 2'd0},
		'{24'h00c55, 24'h00c56, 2'd0}, '{24'h00488, 24'h00489, 2'd0}, '{24'h00e47, 24'h00e4e, 2'd0},
		'{24'h00a81, 24'h00a82, 2'd0}, '{24'h00ac1, 24'h00ac5, 2'd0}, '{24'h0202a, 24'h0202e, 2'd0},
		'{24'h00dd6, 24'h00dd6, 2'd0}, '{24'h018a9, 24'h018a9, 2'd0}, '{24'h0064b, 24'h0065e, 2'd0},
		'{24'h00abc, 24'h00abc, 2'd0}, '{24'h00b82, 24'h00b82, 2'd0}, '{24'h00f39, 24'h00f39, 2'd0},
		'{24'h020d0, 24'h020ef, 2'd0}, '{24'h01dfe, 24'h01dff, 2'd0}, '{24'h30000, 24'h3fffd, 2'd2},
		'{24'h00711, 24'h00711, 2'd0}, '{24'h0fe00, 24'h0fe0f, 2'd0}, '{24'h01160, 24'h011ff, 2'd0},
		'{24'h0180b, 24'h0180d, 2'd0}, '{24'h10a3f, 24'h10a3f, 2'd0}, '{24'h00981, 24'h00981, 2'd0},
		'{24'h0a825, 24'h0a826, 2'd0}, '{24'h00941, 24'h00948, 2'd0}, '{24'h01b6b, 24'h01b73, 2'd0},
		'{24'h00e31, 24'h00e31, 2'd0}, '{24'h0fe10, 24'h0fe19, 2'd2}, '{24'h00a01, 24'h00a02, 2'd0},
		'{24'h00a4b, 24'h00a4d, 2'd0}, '{24'h00f18, 24'h00f19, 2'd0}, '{24'h00fc6, 24'h00fc6, 2'd0},
		'{24'h02e80, 24'h03029, 2'd2}, '{24'h00b56, 24'h00b56, 2'd0}, '{24'h009bc, 24'h009bc, 2'd0},
		'{24'h005c7, 24'h005c7, 2'd0}, '{24'h02060, 24'h02063, 2'd0}, '{24'h00c3e, 24'h00c40, 2'd0},
		'{24'h10a05, 24'h10a06, 2'd0}
	};

	// reset content of one slot: built-in range, zero past the built-in list
	function automatic range_t default_range(logic [IDX_W-1:0] idx);
		logic [ROM_IDX_W-1:0] r;
		r = ROM_IDX_W'(idx);
		if (32'(idx) < RESET_COUNT) begin
			default_range = DEFAULT_TABLE[r];
		end else begin
			default_range = '0;
		end
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} scan_state_t;

	// query start and result hand-off from the top level
	typedef struct packed {
		logic             start;
		logic [CP_W-1:0]  cp;
		logic [CNT_W-1:0] count;
		logic             res_free;
	} scan_ctl_t;

	// table load request
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		range_t           entry;
	} load_t;

	// scan engine status
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [CP_W-1:0]  cp;
		logic [WID_W-1:0] width;
	} scan_stat_t;

endpackage

// ----- rtl/utf8_char_display_width.sv -----
// Query: entries are scanned in slot order, one table entry per cycle, until the first range
// that holds the code point hits or all n entries in use are scanned (a miss, width 1).
// A query holds the input closed until its word moves into the output register, and the
// next word can be accepted in the cycle after that.
// A load is written when it is accepted; the next word is accepted in the following cycle.
// Reset (arst_n low) restores the built-in ranges via written marks, entries_in_use 157.
module utf8_char_display_width import utf8cw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [7:0]       byte_zero,
	input  logic [7:0]       byte_one,
	input  logic [7:0]       byte_two,
	input  logic [7:0]       byte_three,
	input  logic [7:0]       entry_index,
	input  logic [CP_W-1:0]  range_first,
	input  logic [CP_W-1:0]  range_last,
	input  logic [WID_W-1:0] range_width,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CP_W-1:0]  code_point,
	output logic [WID_W-1:0] display_width,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam logic [7:0] BYTE_NONE  = 8'hff;
	localparam logic [7:0] CONT_MASK  = 8'h3f;
	localparam logic [7:0] LEAD2_MASK = 8'h1f;
	localparam logic [7:0] LEAD3_MASK = 8'h0f;
	localparam logic [7:0] LEAD4_MASK = 8'h3f;

	logic [CFG_W-1:0] entries_in_use_q;
	logic             out_valid_q;
	logic [CP_W-1:0]  code_point_q;
	logic [WID_W-1:0] display_width_q;
	logic             in_acc;
	logic [CP_W-1:0]  cp_packed;
	logic [CNT_W-1:0] count_clamped;
	scan_ctl_t        ctl;
	load_t            load;
	scan_stat_t       stat;

	assign in_ready  = stat.idle;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// entries_in_use register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= CFG_RESET;
		end else if (cfg_valid) begin
			entries_in_use_q <= cfg_data;
		end
	end

	// pack utf-8 bytes into a code point
	always_comb begin
		if (byte_one == BYTE_NONE) begin
			cp_packed = CP_W'(byte_zero);
		end else if (byte_two == BYTE_NONE) begin
			cp_packed = (CP_W'(byte_zero & LEAD2_MASK) << 6) | CP_W'(byte_one & CONT_MASK);
		end else if (byte_three == BYTE_NONE) begin
			cp_packed = (CP_W'(byte_zero & LEAD3_MASK) << 12)
				| (CP_W'(byte_one & CONT_MASK) << 6) | CP_W'(byte_two & CONT_MASK);
		end else begin
			cp_packed = (CP_W'(byte_zero & LEAD4_MASK) << 18)
				| (CP_W'(byte_one & CONT_MASK) << 12)
				| (CP_W'(byte_two & CONT_MASK) << 6) | CP_W'(byte_three & CONT_MASK);
		end
	end

	// scan count limited to the table depth
	assign count_clamped = (32'(entries_in_use_q) > TABLE_DEPTH) ?
		CNT_W'(TABLE_DEPTH) : CNT_W'(entries_in_use_q);

	assign ctl.start    = in_acc && (action == ACT_QUERY);
	assign ctl.cp       = cp_packed;
	assign ctl.count    = count_clamped;
	assign ctl.res_free = !out_valid_q || out_ready;

	// loads beyond the table depth are dropped
	assign load.we          = in_acc && (action == ACT_LOAD) && (32'(entry_index) < TABLE_DEPTH);
	assign load.addr        = IDX_W'(entry_index);
	assign load.entry.lo    = range_first;
	assign load.entry.hi    = range_last;
	assign load.entry.width = range_width;

	utf8cw_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.load  (load),
		.stat  (stat)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			code_point_q    <= stat.cp;
			display_width_q <= stat.width;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_point    = code_point_q;
	assign display_width = display_width_q;

endmodule

// ----- rtl/utf8cw_ram.sv -----
module utf8cw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/utf8cw_scan.sv -----
module utf8cw_scan import utf8cw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scan_ctl_t  ctl,
	input  load_t      load,
	output scan_stat_t stat
);

	scan_state_t      state_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [CP_W-1:0]  cp_q;
	logic [WID_W-1:0] width_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic             chk_s1;
	logic             vld_s1;
	range_t           rom_s1;
	logic [RANGE_W-1:0] ram_rdata;
	logic [IDX_W-1:0] rd_addr;
	range_t           ent;
	logic             hit;
	logic             miss;
	logic             issue;

	assign rd_addr = rd_idx_q[IDX_W-1:0];

	// entry under test: loaded value once written, built-in value until then
	assign ent  = vld_s1 ? range_t'(ram_rdata) : rom_s1;
	assign hit  = (state_q == ST_SCAN) && chk_s1 && (cp_q >= ent.lo) && (cp_q <= ent.hi);
	assign miss = (state_q == ST_SCAN) && !chk_s1 && (rd_idx_q >= count_q);
	assign issue = (state_q == ST_SCAN) && (rd_idx_q < count_q) && !hit;

	utf8cw_ram #(
		.WIDTH(RANGE_W),
		.DEPTH(TABLE_DEPTH),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (load.we),
		.waddr(load.addr),
		.wdata(load.entry),
		.re   (issue),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// written-slot marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (load.we) begin
			vld_q[load.addr] <= 1'b1;
		end
	end

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			chk_s1   <= 1'b0;
		end else begin
			chk_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit || miss) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ctl.res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query payload and lookup side data
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && ctl.start) begin
			cp_q    <= ctl.cp;
			count_q <= ctl.count;
		end
		if (hit) begin
			width_q <= ent.width;
		end else if (miss) begin
			width_q <= MISS_WIDTH;
		end
		if (issue) begin
			vld_s1 <= vld_q[rd_addr];
			rom_s1 <= default_range(rd_addr);
		end
	end

	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.done  = (state_q == ST_DONE) && ctl.res_free;
	assign stat.cp    = cp_q;
	assign stat.width = width_q;

endmodule

// ----- tb/tb_utf8_char_display_width.sv -----
`timescale 1ns / 1ps
module tb_utf8_char_display_width;
	import utf8cw_pkg::*;

	localparam int BUILTIN_COUNT  = 157;
	localparam int LOAD_SETTLE    = 8;
	localparam int TAIL_CYCLES    = 300;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 400;

	typedef struct packed {
		logic [CP_W-1:0]  lo;
		logic [CP_W-1:0]  hi;
		logic [WID_W-1:0] width;
	} span_t;

	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [WID_W-1:0] width;
	} glyph_t;

	typedef struct packed {
		logic             act;
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic [7:0]       b3;
		logic [7:0]       slot;
		logic [CP_W-1:0]  lo_cp;
		logic [CP_W-1:0]  hi_cp;
		logic [WID_W-1:0] wid;
	} word_t;

	// width ranges held by the table after reset, slots 0 upward
	localparam span_t BUILTIN_RANGES [BUILTIN_COUNT] = '{
		{24'h00951, 24'h00954, 2'd0}, {24'h00ccc, 24'h00ccd, 2'd0}, {24'h0fff9, 24'h0fffb, 2'd0},
		{24'h20000, 24'h2fffd, 2'd2}, {24'h00ebb, 24'h00ebc, 2'd0}, {24'h01932, 24'h01932, 2'd0},
		{24'h0070f, 24'h0070f, 2'd0}, {24'h00a70, 24'h00a71, 2'd0}, {24'h02329, 24'h02329, 2'd2},
		{24'h00acd, 24'h00acd, 2'd0}, {24'h00ac7, 24'h00ac8, 2'd0}, {24'h00a3c, 24'h00a3c, 2'd0},
		{24'h009cd, 24'h009cd, 2'd0}, {24'h00591, 24'h005bd, 2'd0}, {24'h01058, 24'h01059, 2'd0},
		{24'h0ffe0, 24'h0ffe6, 2'd2}, {24'h01100, 24'h0115f, 2'd2}, {24'h0fe20, 24'h0fe23, 2'd0},
		{24'h0302a, 24'h0302f, 2'd0}, {24'h01772, 24'h01773, 2'd0}, {24'h005bf, 24'h005bf, 2'd0},
		{24'h006ea, 24'h006ed, 2'd0}, {24'h00bc0, 24'h00bc0, 2'd0}, {24'h00962, 24'h00963, 2'd0},
		{24'h01732, 24'h01734, 2'd0}, {24'h00d41, 24'h00d43, 2'd0}, {24'h01b42, 24'h01b42, 2'd0},
		{24'h00a41, 24'h00a42, 2'd0}, {24'h00eb4, 24'h00eb9, 2'd0}, {24'h00b01, 24'h00b01, 2'd0},
		{24'h00e34, 24'h00e3a, 2'd0}, {24'h03040, 24'h03098, 2'd2}, {24'h0093c, 24'h0093c, 2'd0},
		{24'h00c4a, 24'h00c4d, 2'd0}, {24'h01032, 24'h01032, 2'd0}, {24'h00f37, 24'h00f37, 2'd0},
		{24'h00901, 24'h00902, 2'd0}, {24'h00cbf, 24'h00cbf, 2'd0}, {24'h0a806, 24'h0a806, 2'd0},
		{24'h00dd2, 24'h00dd4, 2'd0}, {24'h00f71, 24'h00f7e, 2'd0}, {24'h01752, 24'h01753, 2'd0},
		{24'h1d242, 24'h1d244, 2'd0}, {24'h005c1, 24'h005c2, 2'd0}, {24'h0309b, 24'h0a4cf, 2'd2},
		{24'he0100, 24'he01ef, 2'd0}, {24'h017dd, 24'h017dd, 2'd0}, {24'h00600, 24'h00603, 2'd0},
		{24'h009e2, 24'h009e3, 2'd0}, {24'h00cc6, 24'h00cc6, 2'd0}, {24'h0a80b, 24'h0a80b, 2'd0},
		{24'h01712, 24'h01714, 2'd0}, {24'h00b3c, 24'h00b3c, 2'd0}, {24'h01b00, 24'h01b03, 2'd0},
		{24'h007eb, 24'h007f3, 2'd0}, {24'he0001, 24'he0001, 2'd0}, {24'h1d185, 24'h1d18b, 2'd0},
		{24'h0feff, 24'h0feff, 2'd0}, {24'h01b36, 24'h01b3a, 2'd0}, {24'h01920, 24'h01922, 2'd0},
		{24'h00670, 24'h00670, 2'd0}, {24'h00f90, 24'h00f97, 2'd0}, {24'h01927, 24'h01928, 2'd0},
		{24'h0200b, 24'h0200f, 2'd0}, {24'h0ff00, 24'h0ff60, 2'd2}, {24'h0f900, 24'h0faff, 2'd2},
		{24'h0fb1e, 24'h0fb1e, 2'd0}, {24'h00cbc, 24'h00cbc, 2'd0}, {24'h00eb1, 24'h00eb1, 2'd0},
		{24'h10a38, 24'h10a3a, 2'd0}, {24'h007a6, 24'h007b0, 2'd0}, {24'h00f80, 24'h00f84, 2'd0},
		{24'h005c4, 24'h005c5, 2'd0}, {24'h0ac00, 24'h0d7a3, 2'd2}, {24'h017c9, 24'h017d3, 2'd0},
		{24'h00d4d, 24'h00d4d, 2'd0}, {24'h1d167, 24'h1d169, 2'd0}, {24'h01036, 24'h01037, 2'd0},
		{24'he0020, 24'he007f, 2'd0}, {24'h00f35, 24'h00f35, 2'd0}, {24'h017b4, 24'h017b5, 2'd0},
		{24'h0206a, 24'h0206f, 2'd0}, {24'h00c46, 24'h00c48, 2'd0}, {24'h01939, 24'h0193b, 2'd0},
		{24'h01dc0, 24'h01dca, 2'd0}, {24'h10a0c, 24'h10a0f, 2'd0}, {24'h0102d, 24'h01030, 2'd0},
		{24'h017c6, 24'h017c6, 2'd0}, {24'h00ec8, 24'h00ecd, 2'd0}, {24'h00b41, 24'h00b43, 2'd0},
		{24'h017b7, 24'h017bd, 2'd0}, {24'h1d173, 24'h1d182, 2'd0}, {24'h00a47, 24'h00a48, 2'd0},
		{24'h0232a, 24'h0232a, 2'd2}, {24'h01b3c, 24'h01b3c, 2'd0}, {24'h10a01, 24'h10a03, 2'd0},
		{24'h00ae2, 24'h00ae3, 2'd0}, {24'h00483, 24'h00486, 2'd0}, {24'h0135f, 24'h0135f, 2'd0},
		{24'h01a17, 24'h01a18, 2'd0}, {24'h006e7, 24'h006e8, 2'd0}, {24'h03099, 24'h0309a, 2'd0},
		{24'h00b4d, 24'h00b4d, 2'd0}, {24'h00ce2, 24'h00ce3, 2'd0}, {24'h00bcd, 24'h00bcd, 2'd0},
		{24'h00610, 24'h00615, 2'd0}, {24'h00f99, 24'h00fbc, 2'd0}, {24'h009c1, 24'h009c4, 2'd0},
		{24'h00730, 24'h0074a, 2'd0}, {24'h00300, 24'h0036f, 2'd0}, {24'h03030, 24'h0303e, 2'd2},
		{24'h01b34, 24'h01b34, 2'd0}, {24'h1d1aa, 24'h1d1ad, 2'd0}, {24'h00dca, 24'h00dca, 2'd0},
		{24'h006d6, 24'h006e4, 2'd0}, {24'h00f86, 24'h00f87, 2'd0}, {24'h00b3f, 24'h00b3f, 2'd0},
		{24'h0fe30, 24'h0fe6f, 2'd2}, {24'h01039, 24'h01039, 2'd0}, {24'h0094d, 24'h0094d, 2'd0},
		{24'h00c55, 24'h00c56, 2'd0}, {24'h00488, 24'h00489, 2'd0}, {24'h00e47, 24'h00e4e, 2'd0},
		{24'h00a81, 24'h00a82, 2'd0}, {24'h00ac1, 24'h00ac5, 2'd0}, {24'h0202a, 24'h0202e, 2'd0},
		{24'h00dd6, 24'h00dd6, 2'd0}, {24'h018a9, 24'h018a9, 2'd0}, {24'h0064b, 24'h0065e, 2'd0},
		{24'h00abc, 24'h00abc, 2'd0}, {24'h00b82, 24'h00b82, 2'd0}, {24'h00f39, 24'h00f39, 2'd0},
		{24'h020d0, 24'h020ef, 2'd0}, {24'h01dfe, 24'h01dff, 2'd0}, {24'h30000, 24'h3fffd, 2'd2},
		{24'h00711, 24'h00711, 2'd0}, {24'h0fe00, 24'h0fe0f, 2'd0}, {24'h01160, 24'h011ff, 2'd0},
		{24'h0180b, 24'h0180d, 2'd0}, {24'h10a3f, 24'h10a3f, 2'd0}, {24'h00981, 24'h00981, 2'd0},
		{24'h0a825, 24'h0a826, 2'd0}, {24'h00941, 24'h00948, 2'd0}, {24'h01b6b, 24'h01b73, 2'd0},
		{24'h00e31, 24'h00e31, 2'd0}, {24'h0fe10, 24'h0fe19, 2'd2}, {24'h00a01, 24'h00a02, 2'd0},
		{24'h00a4b, 24'h00a4d, 2'd0}, {24'h00f18, 24'h00f19, 2'd0}, {24'h00fc6, 24'h00fc6, 2'd0},
		{24'h02e80, 24'h03029, 2'd2}, {24'h00b56, 24'h00b56, 2'd0}, {24'h009bc, 24'h009bc, 2'd0},
		{24'h005c7, 24'h005c7, 2'd0}, {24'h02060, 24'h02063, 2'd0}, {24'h00c3e, 24'h00c40, 2'd0},
		{24'h10a05, 24'h10a06, 2'd0}
	};

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	logic             action      = ACT_LOAD;
	logic [7:0]       byte_zero   = '0;
	logic [7:0]       byte_one    = '0;
	logic [7:0]       byte_two    = '0;
	logic [7:0]       byte_three  = '0;
	logic [7:0]       entry_index = '0;
	logic [CP_W-1:0]  range_first = '0;
	logic [CP_W-1:0]  range_last  = '0;
	logic [WID_W-1:0] range_width = '0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	logic [CP_W-1:0]  code_point;
	logic [WID_W-1:0] display_width;
	logic             cfg_valid   = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data    = '0;

	// shadow of the range table and the scan count
	span_t            range_tbl [TABLE_DEPTH];
	logic [CFG_W-1:0] scan_count;
	glyph_t           pending_glyphs [$];

	int mismatches   = 0;
	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	int hold_req_id  = 0;
	int hold_ack_id  = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	utf8_char_display_width u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.byte_zero    (byte_zero),
		.byte_one     (byte_one),
		.byte_two     (byte_two),
		.byte_three   (byte_three),
		.entry_index  (entry_index),
		.range_first  (range_first),
		.range_last   (range_last),
		.range_width  (range_width),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.code_point   (code_point),
		.display_width(display_width),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// pack the bytes: 1-, 2-, 3- or 4-byte masks chosen by the trailing 0xff bytes
	function automatic logic [CP_W-1:0] decode_code_point(word_t w);
		if (w.b1 == 8'hff) begin
			return {16'd0, w.b0};
		end
		if (w.b2 == 8'hff) begin
			return {13'd0, w.b0[4:0], w.b1[5:0]};
		end
		if (w.b3 == 8'hff) begin
			return {8'd0, w.b0[3:0], w.b1[5:0], w.b2[5:0]};
		end
		// four bytes keep six bits of the lead byte
		return {w.b0[5:0], w.b1[5:0], w.b2[5:0], w.b3[5:0]};
	endfunction

	// first range in scan order that holds the code point, else width 1
	function automatic glyph_t lookup_glyph(word_t w);
		glyph_t g;
		int     n;
		g.cp    = decode_code_point(w);
		g.width = 2'd1;
		n       = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
		for (int i = 0; i < n; i++) begin
			if (g.cp >= range_tbl[i].lo && g.cp <= range_tbl[i].hi) begin
				g.width = range_tbl[i].width;
				break;
			end
		end
		return g;
	endfunction

	// query word from raw bytes; load fields carry noise
	function automatic word_t query_of_bytes(logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3);
		word_t w;
		w.act   = ACT_QUERY;
		w.b0    = b0;
		w.b1    = b1;
		w.b2    = b2;
		w.b3    = b3;
		w.slot  = 8'($urandom);
		w.lo_cp = CP_W'($urandom);
		w.hi_cp = CP_W'($urandom);
		w.wid   = WID_W'($urandom);
		return w;
	endfunction

	// encode a code point in the given number of bytes
	function automatic word_t query_of_cp(logic [CP_W-1:0] cp, int nbytes);
		case (nbytes)
			1: begin
				return query_of_bytes(cp[7:0], 8'hff, 8'hff, 8'hff);
			end
			2: begin
				return query_of_bytes({3'b110, cp[10:6]}, {2'b10, cp[5:0]}, 8'hff, 8'hff);
			end
			3: begin
				return query_of_bytes({4'b1110, cp[15:12]}, {2'b10, cp[11:6]},
					{2'b10, cp[5:0]}, 8'hff);
			end
			default: begin
				return query_of_bytes({2'b11, cp[23:18]}, {2'b10, cp[17:12]},
					{2'b10, cp[11:6]}, {2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// load word; byte fields carry noise
	function automatic word_t load_of(logic [7:0] slot, logic [CP_W-1:0] lo,
			logic [CP_W-1:0] hi, logic [WID_W-1:0] wid);
		word_t w;
		w       = query_of_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		w.act   = ACT_LOAD;
		w.slot  = slot;
		w.lo_cp = lo;
		w.hi_cp = hi;
		w.wid   = wid;
		return w;
	endfunction

	// queries: range boundaries, random code points, raw byte noise
	function automatic word_t random_query();
		word_t           w;
		logic [CP_W-1:0] cp;
		int              slot;
		int              nbytes;
		int              pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			slot = ($urandom_range(3) != 0) ? $urandom_range(BUILTIN_COUNT - 1)
				: $urandom_range(TABLE_DEPTH - 1);
			cp   = $urandom_range(1) ? range_tbl[slot].hi : range_tbl[slot].lo;
			cp   = cp + CP_W'($urandom_range(2)) - CP_W'(1);
			if (cp < 24'h100) begin
				nbytes = $urandom_range(1, 4);
			end else if (cp < 24'h800) begin
				nbytes = $urandom_range(2, 4);
			end else if (cp < 24'h10000) begin
				nbytes = $urandom_range(3, 4);
			end else begin
				nbytes = 4;
			end
			w = query_of_cp(cp, nbytes);
		end else if (pick < 70) begin
			nbytes = $urandom_range(1, 4);
			case (nbytes)
				1: cp = CP_W'($urandom_range(8'hff));
				2: cp = CP_W'($urandom_range(11'h7ff));
				3: cp = CP_W'($urandom_range(16'hffff));
				default: cp = $urandom_range(1) ? CP_W'($urandom_range(24'h3ffff))
					: CP_W'($urandom);
			endcase
			w = query_of_cp(cp, nbytes);
		end else begin
			w = query_of_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			nbytes = $urandom_range(1, 4);
			if (nbytes < 2) w.b1 = 8'hff;
			if (nbytes < 3) w.b2 = 8'hff;
			if (nbytes < 4) w.b3 = 8'hff;
		end
		return w;
	endfunction

	// loads: mostly short ranges, some inverted, some fully random
	function automatic word_t random_load();
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
		logic [7:0]      slot;
		int              pick;
		slot = $urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom);
		pick = $urandom_range(99);
		lo   = $urandom_range(1) ? CP_W'($urandom_range(24'h3ffff)) : CP_W'($urandom);
		if (pick < 70) begin
			hi = lo + CP_W'($urandom_range(48));
			if (hi < lo) hi = 24'hffffff;
		end else if (pick < 85) begin
			hi = lo - CP_W'($urandom_range(1, 100));
			if (hi > lo) begin
				hi = lo;
				lo = lo + 24'd1;
			end
		end else begin
			hi = CP_W'($urandom);
		end
		return load_of(slot, lo, hi, WID_W'($urandom));
	endfunction

	// offer one word, hold it until accepted, then update the shadow
	task automatic send_word(word_t w);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= w.act;
		byte_zero   <= w.b0;
		byte_one    <= w.b1;
		byte_two    <= w.b2;
		byte_three  <= w.b3;
		entry_index <= w.slot;
		range_first <= w.lo_cp;
		range_last  <= w.hi_cp;
		range_width <= w.wid;
		do @(posedge clk); while (!in_ready);
		if (w.act == ACT_QUERY) begin
			pending_glyphs.push_back(lookup_glyph(w));
		end else begin
			range_tbl[w.slot] = '{lo: w.lo_cp, hi: w.hi_cp, width: w.wid};
		end
	endtask

	// stop offering and let every expected word arrive, then let a load finish
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	// write the scan count while the block is idle
	task automatic set_entry_count(logic [CFG_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		scan_count = n;
		cfg_valid <= 1'b0;
	endtask

	// reset table: every byte length, range edges, lead byte mask on four bytes
	task automatic test_builtin_ranges();
		send_word(query_of_cp(24'h41, 1));
		send_word(query_of_cp(24'h00, 1));
		send_word(query_of_cp(24'hff, 1));
		send_word(query_of_cp(24'h300, 2));
		send_word(query_of_cp(24'h4e00, 3));
		send_word(query_of_cp(24'h951, 3));
		send_word(query_of_cp(24'h954, 3));
		send_word(query_of_cp(24'h955, 3));
		send_word(query_of_cp(24'h20000, 4));
		send_word(query_of_cp(24'h3fffd, 4));
		send_word(query_of_cp(24'h3fffe, 4));
		// true four-byte encoding of U+E0100 keeps extra lead bits and misses
		send_word(query_of_bytes(8'hf3, 8'ha0, 8'h84, 8'h80));
		send_word(query_of_bytes(8'hfe, 8'hfe, 8'hfe, 8'hfe));
		wait_drained();
	endtask

	// loads: overlap where the lower slot wins, inverted range, last slot
	task automatic test_table_loads();
		send_word(load_of(8'd0, 24'h41, 24'h41, 2'd3));
		send_word(load_of(8'd1, 24'h40, 24'h4f, 2'd2));
		send_word(load_of(8'd2, 24'h60, 24'h50, 2'd3));
		send_word(load_of(8'd255, 24'hffffff, 24'hffffff, 2'd0));
		send_word(query_of_cp(24'h41, 1));
		send_word(query_of_cp(24'h45, 1));
		send_word(query_of_cp(24'h58, 1));
		send_word(query_of_bytes(8'hff, 8'hbf, 8'hbf, 8'hbf));
		wait_drained();
	endtask

	// scan count: full depth, above depth, none, one
	task automatic test_entry_counts();
		set_entry_count(CFG_W'(TABLE_DEPTH));
		send_word(query_of_bytes(8'hff, 8'hbf, 8'hbf, 8'hbf));
		send_word(query_of_cp(24'h00, 1));
		wait_drained();
		set_entry_count('1);
		send_word(query_of_bytes(8'hff, 8'hbf, 8'hbf, 8'hbf));
		wait_drained();
		set_entry_count('0);
		send_word(query_of_cp(24'h300, 2));
		wait_drained();
		set_entry_count(CFG_W'(1));
		send_word(query_of_cp(24'h41, 1));
		send_word(query_of_cp(24'h42, 1));
		wait_drained();
		set_entry_count(CFG_W'(BUILTIN_COUNT));
	endtask

	// long receiver hold-off while queries keep coming, then a drain and mixed loads and queries
	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req_id = hold_req_id + 1;
		for (int i = 0; i < 12; i++) begin
			send_word(random_query());
		end
		wait_drained();
		for (int i = 0; i < 6; i++) begin
			send_word($urandom_range(3) == 0 ? random_load() : random_query());
		end
		wait_drained();
	endtask

	// random traffic under three idling patterns, new scan count per phase
	task automatic test_random_traffic();
		int idle_tx [3];
		int idle_rx [3];
		idle_tx = '{35, 45, 0};
		idle_rx = '{45, 35, 0};
		for (int p = 0; p < 3; p++) begin
			tx_idle_pct = idle_tx[p];
			rx_idle_pct = idle_rx[p];
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				send_word($urandom_range(4) == 0 ? random_load() : random_query());
			end
			wait_drained();
			if ($urandom_range(99) < 80) begin
				set_entry_count(CFG_W'($urandom_range(120, TABLE_DEPTH)));
			end else begin
				set_entry_count(CFG_W'($urandom_range(511)));
			end
		end
	endtask

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_req_id != hold_ack_id) begin
			hold_ack_id = hold_req_id;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// compare each result word with the oldest expected glyph
	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_glyphs.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual code_point %h width %0d",
					$time, code_point, display_width);
				mismatches++;
			end else begin
				want = pending_glyphs.pop_front();
				if (code_point !== want.cp) begin
					$display("%0t: code_point expected %h actual %h",
						$time, want.cp, code_point);
					mismatches++;
				end
				if (display_width !== want.width) begin
					$display("%0t: display_width expected %0d actual %0d (code_point %h)",
						$time, want.width, display_width, want.cp);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			range_tbl[i] = (i < BUILTIN_COUNT) ? BUILTIN_RANGES[i] : '0;
		end
		scan_count = CFG_W'(BUILTIN_COUNT);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_builtin_ranges();
		test_table_loads();
		test_entry_counts();
		test_output_stall();
		test_random_traffic();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
